[sv/ws2s_pkg.sv]
// Shared types and constants for the two-strip WS2812B serializer.
`default_nettype none

package ws2s_pkg;

  // Field widths fixed by the item format.
  localparam int TIME_W       = 16;
  localparam int PIX_CFG_W    = 5;
  localparam int COLOR_W      = 24;
  localparam int POS_W        = 5;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 8;

  // Bit position of the first bit of a pixel; bits are sent MSB first.
  localparam logic [POS_W-1:0] POS_FIRST = 5'd23;

  // Register reset values.
  localparam logic [TIME_W-1:0]    BIT_PERIOD_RST = 16'd270;
  localparam logic [TIME_W-1:0]    ONE_HIGH_RST   = 16'd172;
  localparam logic [TIME_W-1:0]    ZERO_HIGH_RST  = 16'd86;
  localparam logic [PIX_CFG_W-1:0] PIXELS_RST     = 5'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXELS_A   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIXELS_B   = 3'd4;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET     = 2'd1,
    OP_SERVICE = 2'd2
  } op_t;

  // Timing and strip length settings.
  typedef struct packed {
    logic [TIME_W-1:0]    bit_period;
    logic [TIME_W-1:0]    one_high;
    logic [TIME_W-1:0]    zero_high;
    logic [PIX_CFG_W-1:0] pixels_a;
    logic [PIX_CFG_W-1:0] pixels_b;
  } cfg_t;

  // Result of one item.
  typedef struct packed {
    logic busy;
    logic line_b;
    logic line_a;
  } res_t;

endpackage

`default_nettype wire

[sv/ws2812b_two_strip_serializer_core.sv]
// Two-strip WS2812B serializer: handshake, configuration registers and result register.
// A result appears on out_tvalid in the cycle after its item is accepted.
// Throughput: one item per cycle; the input stalls only while a result waits to be taken.
// The bit counters advance once per tick item, so bit timing follows the tick rate.
// Reset (rst_n low, synchronous) restores the default timing, marks both strips
// pending and empties the result register.
`default_nettype none

module ws2812b_two_strip_serializer_core import ws2s_pkg::*; #(
  parameter int MAX_PIXELS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Items in.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // strip, red, green, blue, zero fill
  input  wire logic [1:0]             in_tuser,   // operation
  // Results out.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // line_a, line_b, busy_res, zero fill
  // Configuration writes.
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t  cfg_r;
  res_t  res;
  res_t  res_r;
  logic  out_valid_r, out_valid_nxt;
  logic  in_accept;

  // The result register frees up in the same cycle it is taken.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  ws2s_engine #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_accept),
    .op      (op_t'(in_tuser)),
    .strip   (in_tdata[0]),
    .red     (in_tdata[8:1]),
    .green   (in_tdata[16:9]),
    .blue    (in_tdata[24:17]),
    .cfg     (cfg_r),
    .res     (res)
  );

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_period <= BIT_PERIOD_RST;
      cfg_r.one_high   <= ONE_HIGH_RST;
      cfg_r.zero_high  <= ZERO_HIGH_RST;
      cfg_r.pixels_a   <= PIXELS_RST;
      cfg_r.pixels_b   <= PIXELS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BIT_PERIOD: cfg_r.bit_period <= cfg_data;
        REG_ONE_HIGH:   cfg_r.one_high   <= cfg_data;
        REG_ZERO_HIGH:  cfg_r.zero_high  <= cfg_data;
        REG_PIXELS_A:   cfg_r.pixels_a   <= cfg_data[PIX_CFG_W-1:0];
        REG_PIXELS_B:   cfg_r.pixels_b   <= cfg_data[PIX_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Result register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded with each accepted item.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 3){1'b0}}, res_r.busy, res_r.line_b, res_r.line_a};

endmodule

`default_nettype wire

[sv/ws2s_engine.sv]
// Frame state and item processing for the two-strip serializer; each item's result is combinational.
`default_nettype none

module ws2s_engine import ws2s_pkg::*; #(
  parameter int MAX_PIXELS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire op_t         op,
  input  wire logic        strip,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  input  wire cfg_t        cfg,
  output res_t             res
);

  localparam int PW_RAW = $clog2(MAX_PIXELS + 1);
  localparam int PW     = (PW_RAW < PIX_CFG_W) ? PIX_CFG_W : PW_RAW;
  localparam logic [PW-1:0] MAX_PX = PW'(MAX_PIXELS);

  logic [1:0][COLOR_W-1:0] strip_color_r, strip_color_nxt;
  logic [1:0]              pending_r, pending_nxt;
  logic                    sending_r, sending_nxt;
  logic                    active_r, active_nxt;
  logic [COLOR_W-1:0]      frame_color_r, frame_color_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [PW-1:0]           pixel_r, pixel_nxt;
  logic [TIME_W-1:0]       cycle_r, cycle_nxt;
  logic [PW-1:0]           pixel_inc;
  logic                    lvl_now, lvl_next, lvl;
  logic                    busy;

  // Pixel count of a strip, saturated at the largest supported length.
  function automatic logic [PW-1:0] pixel_count(input logic s, input cfg_t c);
    logic [PW-1:0] n;
    n = s ? PW'(c.pixels_b) : PW'(c.pixels_a);
    return (n > MAX_PX) ? MAX_PX : n;
  endfunction

  // Data line level for a given frame position.
  function automatic logic line_level(input logic snd, input logic [COLOR_W-1:0] col,
                                      input logic [POS_W-1:0] pos,
                                      input logic [TIME_W-1:0] cyc, input cfg_t c);
    logic [TIME_W-1:0] high;
    high = col[pos] ? c.one_high : c.zero_high;
    return snd && (cyc < high);
  endfunction

  assign pixel_inc = pixel_r + PW'(1);

  // Next state for the item at the input.
  always_comb begin
    strip_color_nxt = strip_color_r;
    pending_nxt     = pending_r;
    sending_nxt     = sending_r;
    active_nxt      = active_r;
    frame_color_nxt = frame_color_r;
    pos_nxt         = pos_r;
    pixel_nxt       = pixel_r;
    cycle_nxt       = cycle_r;
    case (op)
      OP_TICK: begin
        if (sending_r) begin
          if ({1'b0, cycle_r} + 17'd1 >= {1'b0, cfg.bit_period}) begin
            // Bit done: step to the next bit or pixel; after the last pixel the frame ends.
            cycle_nxt = '0;
            if (pos_r == '0) begin
              pos_nxt   = POS_FIRST;
              pixel_nxt = pixel_inc;
            end else begin
              pos_nxt = pos_r - POS_W'(1);
            end
            if (pixel_nxt >= pixel_count(active_r, cfg)) begin
              sending_nxt = 1'b0;
              pos_nxt     = POS_FIRST;
              pixel_nxt   = '0;
            end
          end else begin
            cycle_nxt = cycle_r + TIME_W'(1);
          end
        end
      end
      OP_SET: begin
        strip_color_nxt[strip] = {green, red, blue};
        pending_nxt[strip]     = 1'b1;
      end
      OP_SERVICE: begin
        // Start a frame on the first pending strip, strip 0 first.
        if (!sending_r && (pending_r != 2'b00)) begin
          active_nxt               = !pending_r[0];
          pending_nxt[active_nxt]  = 1'b0;
          frame_color_nxt          = strip_color_r[active_nxt];
          pos_nxt                  = POS_FIRST;
          pixel_nxt                = '0;
          cycle_nxt                = '0;
          sending_nxt              = (pixel_count(active_nxt, cfg) != '0);
        end
      end
      default: begin
      end
    endcase
  end

  // A tick reports the cycle it consumes; other items report the state they leave.
  assign lvl_now  = line_level(sending_r, frame_color_r, pos_r, cycle_r, cfg);
  assign lvl_next = line_level(sending_nxt, frame_color_nxt, pos_nxt, cycle_nxt, cfg);
  assign lvl      = (op == OP_TICK) ? lvl_now : lvl_next;
  assign busy     = (op == OP_TICK) ? sending_r : sending_nxt;

  always_comb begin
    res.line_a = lvl && (((op == OP_TICK) ? active_r : active_nxt) == 1'b0);
    res.line_b = lvl && (((op == OP_TICK) ? active_r : active_nxt) == 1'b1);
    res.busy   = busy;
  end

  // State registers, updated once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_color_r <= '0;
      pending_r     <= 2'b11;
      sending_r     <= 1'b0;
      active_r      <= 1'b0;
      frame_color_r <= '0;
      pos_r         <= POS_FIRST;
      pixel_r       <= '0;
      cycle_r       <= '0;
    end else if (step_en) begin
      strip_color_r <= strip_color_nxt;
      pending_r     <= pending_nxt;
      sending_r     <= sending_nxt;
      active_r      <= active_nxt;
      frame_color_r <= frame_color_nxt;
      pos_r         <= pos_nxt;
      pixel_r       <= pixel_nxt;
      cycle_r       <= cycle_nxt;
    end
  end

endmodule

`default_nettype wire
